### rtl/ir_shutter_pulse_sequencer_defines.svh
// assertion macros for the shutter pulse sequencer
`ifndef IR_SHUTTER_PULSE_SEQUENCER_DEFINES_SVH
`define IR_SHUTTER_PULSE_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
	else $error("irsps assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
	else $error("irsps assertion failed");

`else

`define ASSERT_IMPL(name, clk_sig, rst_n_sig, ante, cons)
`define ASSERT_NEXT(name, clk_sig, rst_n_sig, ante, cons)

`endif

`endif

### rtl/irsps_pkg.sv
package irsps_pkg;

	localparam int PATTERN_SEGMENTS_DEF = 8;
	localparam int IDX_W                = 4;

	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam int SEG_LEN_CNT = 7;
	localparam int CARRIER_DIV = 26;
	localparam logic [15:0] GAP_MS       = 16'd63;
	localparam logic [15:0] PREGAP_TICKS = 16'd20;

	localparam logic [15:0] SEG_LEN [SEG_LEN_CNT] = '{
		16'd2000, 16'd27830, 16'd400, 16'd1580, 16'd400, 16'd3580, 16'd400
	};

	// pattern lengths in whole carrier periods
	localparam logic [15:0] SEG_PERIODS [SEG_LEN_CNT] = '{
		16'(SEG_LEN[0] / CARRIER_DIV), 16'(SEG_LEN[1] / CARRIER_DIV),
		16'(SEG_LEN[2] / CARRIER_DIV), 16'(SEG_LEN[3] / CARRIER_DIV),
		16'(SEG_LEN[4] / CARRIER_DIV), 16'(SEG_LEN[5] / CARRIER_DIV),
		16'(SEG_LEN[6] / CARRIER_DIV)
	};

	localparam logic [7:0]  RST_CARRIER_HALF = 8'd13;
	localparam logic [15:0] RST_TICKS_PER_MS = 16'd1000;
	localparam logic [3:0]  RST_BURST_REPS   = 4'd2;
	localparam logic [7:0]  RST_PREFLASH_MS  = 8'd20;

	typedef enum logic [1:0] {
		CFG_CARRIER_HALF = 2'd0,
		CFG_TICKS_PER_MS = 2'd1,
		CFG_BURST_REPS   = 2'd2,
		CFG_PREFLASH_MS  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		REQ_SHOOT   = 3'd0,
		REQ_SILENT  = 3'd1,
		REQ_IR_ON   = 3'd2,
		REQ_RED_ON  = 3'd3,
		REQ_BLINK   = 3'd4,
		REQ_OFF     = 3'd5,
		REQ_RESET   = 3'd6,
		REQ_UNUSED  = 3'd7
	} req_t;

	typedef enum logic [4:0] {
		MODE_IDLE     = 5'b00001,
		MODE_PREFLASH = 5'b00010,
		MODE_PREGAP   = 5'b00100,
		MODE_BURST    = 5'b01000,
		MODE_BLINK    = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [15:0] blink_ms;
		req_t        request;
		logic        action;
	} item_t;

	typedef struct packed {
		logic [7:0]  carrier_half_ticks;
		logic [15:0] ticks_per_ms;
		logic [3:0]  burst_repeats;
		logic [7:0]  preflash_ms;
	} cfg_t;

	typedef struct packed {
		logic busy_res;
		logic red_led;
		logic ir_led;
	} result_t;

	typedef struct packed {
		logic busy;
		logic counters_clear;
	} status_t;

	// index into the seven-entry pattern, for indexes below 16
	function automatic logic [2:0] seg_mod7(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		begin
			if (idx >= IDX_W'(14))
				r = idx - IDX_W'(14);
			else if (idx >= IDX_W'(7))
				r = idx - IDX_W'(7);
			else
				r = idx;
			return r[2:0];
		end
	endfunction

	function automatic logic [15:0] seg_periods(input logic [IDX_W-1:0] idx);
		return SEG_PERIODS[seg_mod7(idx)];
	endfunction

	function automatic logic seg_is_mark(input logic [IDX_W-1:0] idx);
		logic [2:0] m;
		begin
			m = seg_mod7(idx);
			return ~m[0];
		end
	endfunction

endpackage

### rtl/irsps_core.sv
module irsps_core #(
	parameter int PATTERN_SEGMENTS = irsps_pkg::PATTERN_SEGMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  irsps_pkg::item_t   item,
	input  irsps_pkg::cfg_t    cfg,
	output irsps_pkg::result_t res,
	output irsps_pkg::status_t status
);
	import irsps_pkg::*;

	localparam int SEG_W = $clog2(PATTERN_SEGMENTS);
	localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(PATTERN_SEGMENTS - 1);
	localparam logic [SEG_W:0]   SEG_END  = (SEG_W + 1)'(PATTERN_SEGMENTS);

	mode_t            mode_q, mode_n;
	logic [SEG_W-1:0] seg_q, seg_n;
	logic [3:0]       rep_q, rep_n;
	logic [15:0]      sub_q, sub_n;
	logic [15:0]      per_q, per_n;
	logic             ir_q, ir_n;
	logic             red_q, red_n;

	logic [7:0]       half;
	logic [15:0]      ms;
	logic             seg_gap;
	logic             seg_mark;
	logic [15:0]      unit;
	logic [16:0]      sub_inc;
	logic [SEG_W:0]   seg_inc;
	logic [3:0]       rep_inc;
	logic [15:0]      per_dec;
	logic [15:0]      first_periods;
	logic [15:0]      next_periods;
	logic             go_pregap, go_burst, go_idle;

	// zero carrier-half and ticks-per-ms values behave as one
	assign half = (cfg.carrier_half_ticks == 8'd0) ? 8'd1 : cfg.carrier_half_ticks;
	assign ms   = (cfg.ticks_per_ms == 16'd0) ? 16'd1 : cfg.ticks_per_ms;

	assign seg_gap  = (seg_q == LAST_SEG);
	assign seg_mark = !seg_gap && seg_is_mark(IDX_W'(seg_q));

	always_comb begin
		case (mode_q)
			MODE_PREGAP: unit = 16'd1;
			MODE_BURST:  unit = seg_gap ? ms : {7'd0, half, 1'b0};
			default:     unit = ms;
		endcase
	end

	assign sub_inc       = {1'b0, sub_q} + 17'd1;
	assign seg_inc       = {1'b0, seg_q} + (SEG_W + 1)'(1);
	assign rep_inc       = rep_q + 4'd1;
	assign per_dec       = (per_q != 16'd0) ? per_q - 16'd1 : 16'd0;
	assign first_periods = seg_periods(IDX_W'(0));
	assign next_periods  = (seg_inc[SEG_W-1:0] == LAST_SEG) ? GAP_MS
	                       : seg_periods(IDX_W'(seg_inc[SEG_W-1:0]));

	always_comb begin
		mode_n    = mode_q;
		seg_n     = seg_q;
		rep_n     = rep_q;
		sub_n     = sub_q;
		per_n     = per_q;
		ir_n      = ir_q;
		red_n     = red_q;
		go_pregap = 1'b0;
		go_burst  = 1'b0;
		go_idle   = 1'b0;
		res.ir_led   = ir_q;
		res.red_led  = red_q;
		res.busy_res = (mode_q != MODE_IDLE);

		if (!item.action) begin
			// levels during this tick, then advance
			if (mode_q == MODE_BURST && seg_mark)
				res.ir_led = (sub_q < {8'd0, half});
			if (mode_q != MODE_IDLE) begin
				if (sub_inc < {1'b0, unit}) begin
					sub_n = sub_inc[15:0];
				end else begin
					sub_n = 16'd0;
					per_n = per_dec;
					if (per_dec == 16'd0) begin
						case (mode_q)
							MODE_PREFLASH: go_pregap = 1'b1;
							MODE_PREGAP:   go_burst  = 1'b1;
							MODE_BLINK:    go_idle   = 1'b1;
							MODE_BURST: begin
								if (seg_inc >= SEG_END) begin
									seg_n = '0;
									rep_n = rep_inc;
									if (rep_inc >= cfg.burst_repeats)
										go_idle = 1'b1;
									else
										per_n = first_periods;
								end else begin
									seg_n = seg_inc[SEG_W-1:0];
									per_n = next_periods;
								end
							end
							default: ;
						endcase
					end
				end
			end
		end else if (mode_q == MODE_IDLE) begin
			case (item.request)
				REQ_SHOOT: begin
					red_n = 1'b1;
					if (cfg.preflash_ms == 8'd0) begin
						go_pregap = 1'b1;
					end else begin
						mode_n = MODE_PREFLASH;
						sub_n  = 16'd0;
						per_n  = {8'd0, cfg.preflash_ms};
					end
				end
				REQ_SILENT: go_burst = 1'b1;
				REQ_IR_ON:  ir_n = 1'b1;
				REQ_RED_ON: red_n = 1'b1;
				REQ_BLINK: begin
					red_n = 1'b1;
					if (item.blink_ms == 16'd0) begin
						go_idle = 1'b1;
					end else begin
						mode_n = MODE_BLINK;
						sub_n  = 16'd0;
						per_n  = item.blink_ms;
					end
				end
				REQ_OFF: begin
					ir_n  = 1'b0;
					red_n = 1'b0;
				end
				REQ_RESET: go_idle = 1'b1;
				default: ;
			endcase
		end

		if (go_pregap) begin
			ir_n   = 1'b0;
			red_n  = 1'b0;
			mode_n = MODE_PREGAP;
			sub_n  = 16'd0;
			per_n  = PREGAP_TICKS;
		end

		if (go_burst) begin
			ir_n  = 1'b0;
			red_n = 1'b0;
			if (cfg.burst_repeats == 4'd0) begin
				go_idle = 1'b1;
			end else begin
				mode_n = MODE_BURST;
				seg_n  = '0;
				rep_n  = 4'd0;
				sub_n  = 16'd0;
				per_n  = first_periods;
			end
		end

		if (go_idle) begin
			mode_n = MODE_IDLE;
			ir_n   = 1'b0;
			red_n  = 1'b0;
			seg_n  = '0;
			rep_n  = 4'd0;
			sub_n  = 16'd0;
			per_n  = 16'd0;
		end

		// commands report the levels after they take effect
		if (item.action) begin
			res.ir_led   = ir_n;
			res.red_led  = red_n;
			res.busy_res = (mode_n != MODE_IDLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			seg_q  <= '0;
			rep_q  <= 4'd0;
			sub_q  <= 16'd0;
			per_q  <= 16'd0;
			ir_q   <= 1'b0;
			red_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_n;
			seg_q  <= seg_n;
			rep_q  <= rep_n;
			sub_q  <= sub_n;
			per_q  <= per_n;
			ir_q   <= ir_n;
			red_q  <= red_n;
		end
	end

	assign status.busy           = (mode_q != MODE_IDLE);
	assign status.counters_clear = (seg_q == '0) && (rep_q == 4'd0) &&
	                               (sub_q == 16'd0) && (per_q == 16'd0);

endmodule

### rtl/ir_shutter_pulse_sequencer.sv
// channel   | group       | width | contents
// ----------+-------------+-------+--------------------------------------------
// in        | s_axis_*    | 24+1  | tuser: action; tdata: request, blink_ms
// out       | m_axis_*    | 8     | tdata: ir_led, red_led, busy_res
// config    | cfg_*       | 2+16  | index and data, written on cfg_we
//
// one item per cycle sustained while the output is not stalled; an accepted item is
// held in the input register and its result is then registered in the output register
// the sequencer state updates in the same cycle the result is registered
// arst_n clears the valid flags and sequencer state and loads the register defaults; no clearing pass
// a stalled output holds both stages; input is still taken while stage one is free
`include "ir_shutter_pulse_sequencer_defines.svh"

module ir_shutter_pulse_sequencer #(
	parameter int PATTERN_SEGMENTS = irsps_pkg::PATTERN_SEGMENTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [irsps_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // request[2:0], blink_ms[18:3]
	input  logic                             s_axis_tuser,   // action
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [irsps_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // ir_led, red_led, busy_res
	input  logic                             cfg_we,
	input  irsps_pkg::cfg_idx_t              cfg_index,
	input  logic [irsps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import irsps_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t core_res;
	status_t core_status;
	logic    advance;
	logic    step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carrier_half_ticks <= RST_CARRIER_HALF;
			cfg_q.ticks_per_ms       <= RST_TICKS_PER_MS;
			cfg_q.burst_repeats      <= RST_BURST_REPS;
			cfg_q.preflash_ms        <= RST_PREFLASH_MS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CARRIER_HALF: cfg_q.carrier_half_ticks <= cfg_data[7:0];
				CFG_TICKS_PER_MS: cfg_q.ticks_per_ms       <= cfg_data;
				CFG_BURST_REPS:   cfg_q.burst_repeats      <= cfg_data[3:0];
				CFG_PREFLASH_MS:  cfg_q.preflash_ms        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// output stage moves when empty or its transfer completes
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign step          = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.action   <= s_axis_tuser;
			item_s1.request  <= req_t'(s_axis_tdata[2:0]);
			item_s1.blink_ms <= s_axis_tdata[18:3];
		end
		if (step)
			res_s2 <= core_res;
	end

	irsps_core #(
		.PATTERN_SEGMENTS(PATTERN_SEGMENTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (core_res),
		.status (core_status)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, res_s2.busy_res, res_s2.red_led, res_s2.ir_led};

	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(item_s1))
	`ASSERT_NEXT(a_s2_load, clk, arst_n, advance, valid_s2 == $past(valid_s1))
	`ASSERT_IMPL(a_idle_clear, clk, arst_n, !core_status.busy, core_status.counters_clear)

endmodule
